// ===== hdl/dmp_config_set_loader_unit_defines.svh =====
// Assertion macros shared by the configuration-set loader RTL.
`ifndef DMP_CONFIG_SET_LOADER_UNIT_DEFINES_SVH
`define DMP_CONFIG_SET_LOADER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is high.
`define DMPCFG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset.
`define DMPCFG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DMPCFG_ASSERT(lbl, clk, rst, prop, msg)
`define DMPCFG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/dmpcfg_pkg.sv =====
// Types, codes and constants of the configuration-set loader.
package dmpcfg_pkg;

  localparam int BANK_BITS = 5;

  localparam logic [2:0] PH_BANK    = 3'd0;
  localparam logic [2:0] PH_OFFSET  = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_SPECIAL = 3'd4;
  localparam logic [2:0] PH_DROP    = 3'd5;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_INTEN = 2'd1;
  localparam logic [1:0] ACT_ERROR = 2'd2;
  localparam logic [1:0] ACT_TRUNC = 2'd3;

  localparam logic [7:0] SPECIAL_INTEN = 8'h01;
  localparam logic [7:0] INTEN_VALUE   = 8'h32;

  typedef struct packed {
    logic [7:0] set_byte;
    logic       set_end;
  } set_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] mem_bank;
    logic [7:0] mem_address;
    logic [7:0] write_value;
    logic       final_res;
  } res_item_t;

  typedef struct packed {
    logic valid;  // stage register holds an item
    logic adv;    // that item moves on this cycle
  } stage_ctl_t;

endpackage

// ===== hdl/dmpcfg_in_stage.sv =====
// Input skid buffer and stage register of the configuration-set loader.
`include "dmp_config_set_loader_unit_defines.svh"

module dmpcfg_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  set_valid,
  output logic                  set_ready,
  input  dmpcfg_pkg::set_item_t set_item,
  input  logic                  take,
  output dmpcfg_pkg::stage_ctl_t ctl,
  output dmpcfg_pkg::set_item_t stage_item
);

  logic                  s1_valid;
  dmpcfg_pkg::set_item_t s1_item;
  logic                  skid_valid;
  dmpcfg_pkg::set_item_t skid_item;
  logic                  s1_adv;
  logic                  s1_free;
  logic                  in_fire;

  assign set_ready = !skid_valid;
  assign in_fire   = set_valid && set_ready;
  assign s1_adv    = s1_valid && take;
  assign s1_free   = !s1_valid || s1_adv;

  assign ctl.valid  = s1_valid;
  assign ctl.adv    = s1_adv;
  assign stage_item = s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        if (skid_valid) begin
          s1_valid   <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          s1_valid <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      if (skid_valid) begin
        s1_item <= skid_item;
      end else if (in_fire) begin
        s1_item <= set_item;
      end
    end else if (in_fire) begin
      skid_item <= set_item;
    end
  end

  `DMPCFG_ASSERT(a_skid_behind_stage, clk, rst, skid_valid |-> s1_valid,
                 "skid holds an item while the stage register is empty")
  `DMPCFG_ASSERT(a_stage_holds, clk, rst,
                 s1_valid && !s1_adv |=> s1_valid && $stable(s1_item),
                 "stalled stage item lost or changed")
  `DMPCFG_ASSERT(a_skid_holds, clk, rst,
                 skid_valid && !s1_adv |=> skid_valid && $stable(skid_item),
                 "stalled skid item lost or changed")

endmodule

// ===== hdl/dmpcfg_parser.sv =====
// Record parser: phase, bank, address and count state plus result decode.
`include "dmp_config_set_loader_unit_defines.svh"

module dmpcfg_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  dmpcfg_pkg::stage_ctl_t ctl,
  input  dmpcfg_pkg::set_item_t  item,
  output logic                   res_has,
  output dmpcfg_pkg::res_item_t  res
);

  logic [2:0]                       phase;
  logic [2:0]                       phase_next;
  logic [dmpcfg_pkg::BANK_BITS-1:0] cur_bank;
  logic [dmpcfg_pkg::BANK_BITS-1:0] cur_bank_next;
  logic [7:0]                       cur_addr;
  logic [7:0]                       cur_addr_next;
  logic [7:0]                       bytes_left;
  logic [7:0]                       bytes_left_next;
  logic [7:0]                       left_dec;

  // Remaining count after this payload byte, floored at zero.
  assign left_dec = (bytes_left == 8'd0) ? 8'd0 : bytes_left - 8'd1;

  always_comb begin
    phase_next      = phase;
    cur_bank_next   = cur_bank;
    cur_addr_next   = cur_addr;
    bytes_left_next = bytes_left;
    res_has         = 1'b0;
    res             = '0;
    case (phase)
      dmpcfg_pkg::PH_OFFSET: begin
        if (item.set_end) begin
          phase_next    = dmpcfg_pkg::PH_BANK;
          res_has       = 1'b1;
          res.action    = dmpcfg_pkg::ACT_TRUNC;
          res.final_res = 1'b1;
        end else begin
          cur_addr_next = item.set_byte;
          phase_next    = dmpcfg_pkg::PH_LENGTH;
        end
      end
      dmpcfg_pkg::PH_LENGTH: begin
        if (item.set_end) begin
          phase_next    = dmpcfg_pkg::PH_BANK;
          res_has       = 1'b1;
          res.action    = dmpcfg_pkg::ACT_TRUNC;
          res.final_res = 1'b1;
        end else begin
          bytes_left_next = item.set_byte;
          phase_next      = (item.set_byte != 8'd0) ? dmpcfg_pkg::PH_PAYLOAD
                                                    : dmpcfg_pkg::PH_SPECIAL;
        end
      end
      dmpcfg_pkg::PH_PAYLOAD: begin
        res_has = 1'b1;
        if (item.set_end && (left_dec != 8'd0)) begin
          phase_next      = dmpcfg_pkg::PH_BANK;
          bytes_left_next = 8'd0;
          res.action      = dmpcfg_pkg::ACT_TRUNC;
          res.final_res   = 1'b1;
        end else begin
          bytes_left_next = left_dec;
          cur_addr_next   = cur_addr + 8'd1;
          // bank steps when the address wraps
          if (cur_addr == 8'hFF) begin
            cur_bank_next = cur_bank + 1'b1;
          end
          if (left_dec == 8'd0) begin
            phase_next = dmpcfg_pkg::PH_BANK;
          end
          res.action      = dmpcfg_pkg::ACT_WRITE;
          res.mem_bank    = 5'(cur_bank);
          res.mem_address = cur_addr;
          res.write_value = item.set_byte;
          res.final_res   = item.set_end;
        end
      end
      dmpcfg_pkg::PH_SPECIAL: begin
        res_has       = 1'b1;
        res.final_res = item.set_end;
        if (item.set_byte == dmpcfg_pkg::SPECIAL_INTEN) begin
          phase_next      = dmpcfg_pkg::PH_BANK;
          res.action      = dmpcfg_pkg::ACT_INTEN;
          res.write_value = dmpcfg_pkg::INTEN_VALUE;
        end else begin
          phase_next = item.set_end ? dmpcfg_pkg::PH_BANK : dmpcfg_pkg::PH_DROP;
          res.action = dmpcfg_pkg::ACT_ERROR;
        end
      end
      dmpcfg_pkg::PH_DROP: begin
        if (item.set_end) begin
          phase_next = dmpcfg_pkg::PH_BANK;
        end
      end
      default: begin
        // bank byte; unused phase codes land here too
        if (item.set_end) begin
          phase_next    = dmpcfg_pkg::PH_BANK;
          res_has       = 1'b1;
          res.action    = dmpcfg_pkg::ACT_TRUNC;
          res.final_res = 1'b1;
        end else begin
          cur_bank_next = item.set_byte[dmpcfg_pkg::BANK_BITS-1:0];
          phase_next    = dmpcfg_pkg::PH_OFFSET;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dmpcfg_pkg::PH_BANK;
      cur_bank   <= '0;
      cur_addr   <= 8'd0;
      bytes_left <= 8'd0;
    end else if (ctl.adv) begin
      phase      <= phase_next;
      cur_bank   <= cur_bank_next;
      cur_addr   <= cur_addr_next;
      bytes_left <= bytes_left_next;
    end
  end

  `DMPCFG_ASSERT(a_adv_has_item, clk, rst, ctl.adv |-> ctl.valid,
                 "parser advanced with no item in the stage register")
  `DMPCFG_ASSERT(a_end_resyncs, clk, rst,
                 ctl.adv && item.set_end |=> phase == dmpcfg_pkg::PH_BANK,
                 "set end did not return the parser to the bank byte")
  `DMPCFG_ASSERT(a_payload_count, clk, rst,
                 phase == dmpcfg_pkg::PH_PAYLOAD |-> bytes_left != 8'd0,
                 "payload phase with no bytes left")
  `DMPCFG_ASSERT(a_trunc_only_at_end, clk, rst,
                 ctl.adv && res_has && res.action == dmpcfg_pkg::ACT_TRUNC
                   |-> item.set_end && res.final_res,
                 "truncation reported away from the end of a set")

endmodule

// ===== hdl/dmpcfg_out_reg.sv =====
// Result register of the configuration-set loader.
module dmpcfg_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  res_has,
  input  dmpcfg_pkg::res_item_t res,
  output logic                  res_valid,
  input  logic                  res_ready,
  output dmpcfg_pkg::res_item_t res_item
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= res_has;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_has) begin
      res_item <= res;
    end
  end

endmodule

// ===== hdl/dmp_config_set_loader_unit.sv =====
// Top level of the configuration-set loader.
//
// Takes a configuration set one byte per transfer and turns it into memory
// writes and control actions. A set is a chain of records: bank byte, offset
// byte, length byte, then that many payload bytes, each of which comes out as
// one memory write at the running bank/address (address wraps at 256 and
// bumps the bank). A zero length is followed by one special byte: 0x01 gives
// an interrupt-enable action with value 0x32; anything else gives an error
// and the rest of the set is dropped. A set that ends mid-record gives a
// truncation result. set_end marks the last byte; final_res marks a result
// made by that byte. Throughput is one byte per cycle while the receiver keeps
// res_ready high: each byte passes a stage register, the combinational
// parser logic and the result register, whose load raises res_valid for
// the result transfer. Bytes that make no result (header bytes,
// dropped bytes) make no output transfer. set_ready comes straight from a
// flop (a one-entry skid buffer), so there is no combinational path from
// res_ready to set_ready. No configuration registers; reset is synchronous
// and active high.

module dmp_config_set_loader_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  set_valid,
  output logic                  set_ready,
  input  dmpcfg_pkg::set_item_t set_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output dmpcfg_pkg::res_item_t res_item
);

  dmpcfg_pkg::stage_ctl_t ctl;
  dmpcfg_pkg::set_item_t  stage_item;
  dmpcfg_pkg::res_item_t  res;
  logic                   res_has;
  logic                   take;

  // Stage may move when the result register is empty or drains this cycle.
  assign take = !res_valid || res_ready;

  dmpcfg_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .set_valid  (set_valid),
    .set_ready  (set_ready),
    .set_item   (set_item),
    .take       (take),
    .ctl        (ctl),
    .stage_item (stage_item)
  );

  // Parser state advances only when the stage item transfers onward.
  dmpcfg_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .item    (stage_item),
    .res_has (res_has),
    .res     (res)
  );

  dmpcfg_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (ctl.adv),
    .res_has   (res_has),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the configuration-set loader (dmp_config_set_loader_unit).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  set_valid = 1'b0;
  logic                  set_ready;
  dmpcfg_pkg::set_item_t set_item  = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  dmpcfg_pkg::res_item_t res_item;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dmp_config_set_loader_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .set_valid (set_valid),
    .set_ready (set_ready),
    .set_item  (set_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: record parser position, running bank/address and the
  // payload bytes still owed by the current record.
  // ---------------------------------------------------------------------------
  logic [2:0]                       pr_phase = dmpcfg_pkg::PH_BANK;
  logic [dmpcfg_pkg::BANK_BITS-1:0] pr_bank  = '0;
  logic [7:0]                       pr_addr  = '0;
  logic [7:0]                       pr_left  = '0;

  dmpcfg_pkg::res_item_t pending_results[$];  // results owed by the block, oldest first
  int        errors = 0;

  // Idle/stall knobs, in percent per cycle; changed per stimulus phase.
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  // Long receiver hold-off: main raises the request, receiver counts it down.
  bit        hold_req  = 1'b0;
  int        hold_left = 0;

  // Advance the parser by one set byte; returns 1 when the byte makes a result.
  // final_res always follows set_end of the byte that made the result.
  function automatic bit parse_set_byte(input dmpcfg_pkg::set_item_t it,
                                        output dmpcfg_pkg::res_item_t r);
    logic [7:0] remain;
    r = '0;
    r.final_res = it.set_end;
    case (pr_phase)
      dmpcfg_pkg::PH_OFFSET: begin
        if (it.set_end) begin
          pr_phase = dmpcfg_pkg::PH_BANK;
          r.action = dmpcfg_pkg::ACT_TRUNC;
          return 1'b1;
        end
        pr_addr  = it.set_byte;
        pr_phase = dmpcfg_pkg::PH_LENGTH;
        return 1'b0;
      end
      dmpcfg_pkg::PH_LENGTH: begin
        if (it.set_end) begin
          pr_phase = dmpcfg_pkg::PH_BANK;
          r.action = dmpcfg_pkg::ACT_TRUNC;
          return 1'b1;
        end
        pr_left  = it.set_byte;
        pr_phase = (it.set_byte != 8'd0) ? dmpcfg_pkg::PH_PAYLOAD : dmpcfg_pkg::PH_SPECIAL;
        return 1'b0;
      end
      dmpcfg_pkg::PH_PAYLOAD: begin
        remain = (pr_left == 8'd0) ? 8'd0 : pr_left - 8'd1;
        // set ends before the record's last payload byte: no write
        if (it.set_end && remain != 8'd0) begin
          pr_phase = dmpcfg_pkg::PH_BANK;
          pr_left  = 8'd0;
          r.action = dmpcfg_pkg::ACT_TRUNC;
          return 1'b1;
        end
        r.action      = dmpcfg_pkg::ACT_WRITE;
        r.mem_bank    = pr_bank;
        r.mem_address = pr_addr;
        r.write_value = it.set_byte;
        pr_left = remain;
        pr_addr = pr_addr + 8'd1;
        if (pr_addr == 8'd0) pr_bank = pr_bank + 1'b1;  // address wrap bumps bank
        if (remain == 8'd0) pr_phase = dmpcfg_pkg::PH_BANK;
        return 1'b1;
      end
      dmpcfg_pkg::PH_SPECIAL: begin
        if (it.set_byte == dmpcfg_pkg::SPECIAL_INTEN) begin
          pr_phase      = dmpcfg_pkg::PH_BANK;
          r.action      = dmpcfg_pkg::ACT_INTEN;
          r.write_value = dmpcfg_pkg::INTEN_VALUE;
          return 1'b1;
        end
        pr_phase = it.set_end ? dmpcfg_pkg::PH_BANK : dmpcfg_pkg::PH_DROP;
        r.action = dmpcfg_pkg::ACT_ERROR;
        return 1'b1;
      end
      dmpcfg_pkg::PH_DROP: begin
        if (it.set_end) pr_phase = dmpcfg_pkg::PH_BANK;
        return 1'b0;
      end
      default: begin  // bank byte, and any stray phase code
        if (it.set_end) begin
          pr_phase = dmpcfg_pkg::PH_BANK;
          r.action = dmpcfg_pkg::ACT_TRUNC;
          return 1'b1;
        end
        pr_bank  = it.set_byte[dmpcfg_pkg::BANK_BITS-1:0];
        pr_phase = dmpcfg_pkg::PH_OFFSET;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic dmpcfg_pkg::set_item_t mk_item(input logic [7:0] b, input logic last);
    dmpcfg_pkg::set_item_t it;
    it.set_byte = b;
    it.set_end  = last;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call. Random idle cycles first, then valid
  // stays up with a fixed payload until set_ready is seen at a rising edge.
  // Returns at the falling edge after the transfer.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input dmpcfg_pkg::set_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      set_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    set_valid <= 1'b1;
    set_item  <= it;
    do @(posedge clk); while (!set_ready);
    @(negedge clk);
  endtask

  task automatic send_and_predict(input dmpcfg_pkg::set_item_t it);
    dmpcfg_pkg::res_item_t r;
    send_byte(it);
    if (parse_set_byte(it, r)) pending_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: rows with a typed-in result check against it; the rest
  // check against the predictor's result, if they make one.
  // ---------------------------------------------------------------------------
  typedef struct {
    dmpcfg_pkg::set_item_t item;
    bit                    typed;
    dmpcfg_pkg::res_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void row(input logic [7:0] b, input logic last);
    dir_row_t d;
    d.item  = mk_item(b, last);
    d.typed = 1'b0;
    d.want  = '0;
    dir_rows.push_back(d);
  endfunction

  function automatic void row_res(input logic [7:0] b, input logic last,
                                  input logic [1:0] act, input logic [4:0] bank,
                                  input logic [7:0] addr, input logic [7:0] val);
    dir_row_t d;
    d.item  = mk_item(b, last);
    d.typed = 1'b1;
    d.want  = '{action: act, mem_bank: bank, mem_address: addr,
                write_value: val, final_res: last};
    dir_rows.push_back(d);
  endfunction

  // ---------------------------------------------------------------------------
  // Random sets: mostly well-formed record chains with random content, some
  // cut short at a random byte, some pure noise.
  // ---------------------------------------------------------------------------
  dmpcfg_pkg::set_item_t set_q[$];

  task automatic build_set();
    int kind, nrec, sel, len, k;
    set_q.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      // noise: random bytes, random set_end, last one closes the set
      repeat ($urandom_range(10, 1))
        set_q.push_back(mk_item(8'($urandom_range(255)), $urandom_range(7) == 0));
    end else begin
      nrec = $urandom_range(4, 1);
      repeat (nrec) begin
        set_q.push_back(mk_item(8'($urandom_range(255)), 1'b0));
        // bias the offset toward the top so writes wrap into the next bank
        if ($urandom_range(3) == 0)
          set_q.push_back(mk_item(8'(8'hF8 + $urandom_range(7)), 1'b0));
        else
          set_q.push_back(mk_item(8'($urandom_range(255)), 1'b0));
        sel = $urandom_range(99);
        if (sel < 15) begin
          set_q.push_back(mk_item(8'd0, 1'b0));
          if ($urandom_range(3) == 0)
            set_q.push_back(mk_item(8'($urandom_range(255)), 1'b0));
          else
            set_q.push_back(mk_item(dmpcfg_pkg::SPECIAL_INTEN, 1'b0));
        end else begin
          len = (sel < 16) ? $urandom_range(255, 100) : $urandom_range(6, 1);
          set_q.push_back(mk_item(len[7:0], 1'b0));
          repeat (len) set_q.push_back(mk_item(8'($urandom_range(255)), 1'b0));
        end
      end
      // broken set: cut anywhere
      if (kind < 22) begin
        k = $urandom_range(set_q.size() - 1);
        while (set_q.size() > k + 1) void'(set_q.pop_back());
      end
    end
    set_q[set_q.size() - 1].set_end = 1'b1;
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct, input int n_items);
    int sent;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      build_set();
      foreach (set_q[i]) send_and_predict(set_q[i]);
      sent += set_q.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side. res_ready changes at the falling edge; a long hold-off runs
  // first whenever requested, otherwise the stall percentage applies.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%02h, got 0x%02h", $time, name, want, got);
    end
  endtask

  // Result transfers are compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    dmpcfg_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %p",
                 $time, res_item);
      end else begin
        want = pending_results.pop_front();
        check_field("action",      8'(want.action),      8'(res_item.action));
        check_field("mem_bank",    8'(want.mem_bank),    8'(res_item.mem_bank));
        check_field("mem_address", want.mem_address,     res_item.mem_address);
        check_field("write_value", want.write_value,     res_item.write_value);
        check_field("final_res",   8'(want.final_res),   8'(res_item.final_res));
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    dmpcfg_pkg::res_item_t r;
    bit                    got;

    // Directed rows.
    // two-byte write at bank 31, offset 0xFF: address wraps, bank wraps to 0
    row(8'hFF, 1'b0);
    row(8'hFF, 1'b0);
    row(8'h02, 1'b0);
    row_res(8'hAA, 1'b0, dmpcfg_pkg::ACT_WRITE, 5'd31, 8'hFF, 8'hAA);
    row_res(8'h55, 1'b1, dmpcfg_pkg::ACT_WRITE, 5'd0,  8'h00, 8'h55);
    // bank byte keeps only its low bits; interrupt enable
    row(8'h80, 1'b0);
    row(8'h00, 1'b0);
    row(8'h00, 1'b0);
    row_res(dmpcfg_pkg::SPECIAL_INTEN, 1'b0, dmpcfg_pkg::ACT_INTEN, 5'd0, 8'h00,
            dmpcfg_pkg::INTEN_VALUE);
    // unknown special, then the rest of the set is dropped silently
    row(8'h7F, 1'b0);
    row(8'h7F, 1'b0);
    row(8'h00, 1'b0);
    row_res(8'hFF, 1'b0, dmpcfg_pkg::ACT_ERROR, 5'd0, 8'h00, 8'h00);
    row(8'h00, 1'b1);
    // set ends on a bank, offset and length byte
    row_res(8'h01, 1'b1, dmpcfg_pkg::ACT_TRUNC, 5'd0, 8'h00, 8'h00);
    row(8'h01, 1'b0);
    row_res(8'h02, 1'b1, dmpcfg_pkg::ACT_TRUNC, 5'd0, 8'h00, 8'h00);
    row(8'h1F, 1'b0);
    row(8'h03, 1'b0);
    row_res(8'h05, 1'b1, dmpcfg_pkg::ACT_TRUNC, 5'd0, 8'h00, 8'h00);
    // set ends on a payload byte that is not the record's last
    row(8'h00, 1'b0);
    row(8'h00, 1'b0);
    row(8'h03, 1'b0);
    row_res(8'hFF, 1'b0, dmpcfg_pkg::ACT_WRITE, 5'd0, 8'h00, 8'hFF);
    row_res(8'h00, 1'b1, dmpcfg_pkg::ACT_TRUNC, 5'd0, 8'h00, 8'h00);

    // Reset: held from time zero, released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].item);
      got = parse_set_byte(dir_rows[i].item, r);
      if (dir_rows[i].typed) pending_results.push_back(dir_rows[i].want);
      else if (got) pending_results.push_back(r);
    end

    // Random phases. The first opens with a long receiver hold-off while the
    // sender keeps pushing, so the block fills and drops set_ready.
    hold_req = 1'b1;
    run_phase(0,  0,  175);
    run_phase(59, 0,  175);
    run_phase(0,  59, 175);
    run_phase(30, 30, 175);
    set_valid <= 1'b0;

    // Drain, then keep clocking so that stray results show.
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
